/* rtl/dce_pkg.sv */
package dce_pkg;

   localparam int MAX_COMP = 16;
   localparam int COMP_W   = 4;
   localparam int CNT_W    = 5;
   localparam int DATA_W   = 32;
   localparam int SUM_W    = 34;
   localparam int DCNT_W   = 6;

   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_TRIVIAL = 3'd1;
   localparam logic [2:0] OP_NEXT    = 3'd2;
   localparam logic [2:0] OP_PRIM    = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   localparam logic [1:0] CSR_MODULUS  = 2'd0;
   localparam logic [1:0] CSR_GROUPEXP = 2'd1;
   localparam logic [1:0] CSR_NCOMP    = 2'd2;
   localparam logic [1:0] CSR_ESPLIT   = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_MUL_START, S_RA_ISSUE, S_RA_WAIT, S_RB_ISSUE, S_RB_WAIT,
      S_MUL_RUN, S_STEP, S_PR_ISSUE, S_PR_WAIT, S_DECIDE, S_GCD_ADDR, S_GCD_LOAD,
      S_GCD_RUN, S_OR_ISSUE, S_OR_WAIT, S_RD_ADDR, S_RD_ISSUE, S_RD_WAIT, S_FINISH
   } state_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic              busy;
      logic [SUM_W-1:0]  quotient;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* rtl/dce_div.sv */
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module dce_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dce_pkg::div_req_type div_req,
   output dce_pkg::div_rsp_type div_rsp
);
   import dce_pkg::*;

   logic              busy_ff, done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DATA_W-1:0] rem_ff, dvs_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [DATA_W:0]   trial, diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.busy      = busy_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* rtl/dirichlet_character_enumerator.sv */
// Dirichlet character enumerator.
// Input channel req_*: one transfer is one operation (load component, trivial
// character, next, next primitive, read exponent). req_stall is high while an
// operation is in work; the block takes one operation at a time.
// Result channel rsp_*: exactly one transfer per operation, held in an output
// register until rsp_stall is low; the engine may accept the next operation
// while a result waits, but cannot retire it until the output register frees.
// csr_*: register writes, only while idle.
// Latency depends on the data. Every index update is a modular product:
// two serial reductions mod q (skipped when q is zero) plus a bit-serial
// multiply. Each component a next step walks costs one such product
// (primitive steps add a prime test and maybe a second product). The order
// is then built by a binary gcd over all active exponents and one division,
// plus one more for a read. The shared serial divider and the serial
// multiplier set this latency.
// Reset (synchronous, active high): index 1, all exponents zero (valid bits
// cleared), registers modulus 1, group exponent 1, one component, no split.
module dirichlet_character_enumerator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_opcode,
   input  logic [dce_pkg::COMP_W-1:0]   req_component,
   input  logic [dce_pkg::DATA_W-1:0]   req_generator_value,
   input  logic [dce_pkg::DATA_W-1:0]   req_phi_step,
   input  logic [dce_pkg::DATA_W-1:0]   req_prime_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dce_pkg::DATA_W-1:0]   rsp_char_index,
   output logic [dce_pkg::DATA_W-1:0]   rsp_char_order,
   output logic [dce_pkg::CNT_W-1:0]    rsp_last_modified,
   output logic [dce_pkg::DATA_W-1:0]   rsp_exponent_read,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [dce_pkg::DATA_W-1:0]   csr_wdata
);
   import dce_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic [DATA_W-1:0] modulus_ff, gexp_ff;
   logic [CNT_W-1:0]  ncomp_ff, act_cnt;
   logic              esplit_ff;

   // tables
   logic [DATA_W-1:0] gen_mem [MAX_COMP];
   logic [DATA_W-1:0] phi_mem [MAX_COMP];
   logic [DATA_W-1:0] pri_mem [MAX_COMP];
   logic [DATA_W-1:0] exp_mem [MAX_COMP];
   logic [MAX_COMP-1:0] exp_vld_ff;
   logic [DATA_W-1:0] gen_q_ff, phi_q_ff, pri_q_ff, exp_q_ff;
   logic [COMP_W-1:0] rd_addr;
   logic              tbl_rd;

   // operation context
   logic [2:0]        op_ff;
   logic [COMP_W-1:0] comp_ff;
   logic [CNT_W-1:0]  k_ff, j_ff, k_inc, last_ff;
   logic              spec_ff, second_ff;
   logic [DATA_W-1:0] idx_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [DATA_W-1:0] order_ff, readv_ff;

   // serial modular multiply
   logic [DATA_W-1:0] mul_a_ff, mul_b_ff, mul_r_ff, mul_r_in;
   logic [CNT_W-1:0]  mul_cnt_ff;
   logic [DATA_W:0]   dbl, dbl_red, addv, add_red;
   logic              q_zero;

   // binary gcd
   logic [DATA_W-1:0] g_ff, ga_ff, gb_ff, ga_in, gb_in, g_res;
   logic [CNT_W-1:0]  sh_ff, sh_in;
   logic              g_done;

   // output register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_index_ff, rsp_order_ff, rsp_read_ff;
   logic [CNT_W-1:0]  rsp_last_ff;
   logic              slot_free, accept;

   div_req_type div_req;
   div_rsp_type div_rsp;

   dce_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign act_cnt   = (ncomp_ff > CNT_W'(MAX_COMP)) ? CNT_W'(MAX_COMP) : ncomp_ff;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_zero    = (modulus_ff == '0);
   assign k_inc     = k_ff + 1'b1;

   // one Horner step of the product: r = 2r + bit*a, reduced mod q
   always_comb begin
      dbl     = {mul_r_ff, 1'b0};
      dbl_red = (!q_zero && dbl >= {1'b0, modulus_ff}) ? dbl - {1'b0, modulus_ff} : dbl;
      addv    = dbl_red + (mul_b_ff[DATA_W-1] ? {1'b0, mul_a_ff} : '0);
      add_red = (!q_zero && addv >= {1'b0, modulus_ff}) ? addv - {1'b0, modulus_ff} : addv;
      mul_r_in = add_red[DATA_W-1:0];
   end

   // one binary gcd step
   always_comb begin
      ga_in  = ga_ff;
      gb_in  = gb_ff;
      sh_in  = sh_ff;
      g_done = 1'b0;
      g_res  = '0;
      if (ga_ff == '0) begin
         g_done = 1'b1;
         g_res  = gb_ff << sh_ff;
      end else if (gb_ff == '0) begin
         g_done = 1'b1;
         g_res  = ga_ff << sh_ff;
      end else if (!ga_ff[0] && !gb_ff[0]) begin
         ga_in = ga_ff >> 1;
         gb_in = gb_ff >> 1;
         sh_in = sh_ff + 1'b1;
      end else if (!ga_ff[0]) begin
         ga_in = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         gb_in = gb_ff >> 1;
      end else if (ga_ff >= gb_ff) begin
         ga_in = ga_ff - gb_ff;
      end else begin
         gb_in = gb_ff - ga_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_NEXT)
                  state_in = (act_cnt == '0) ? S_GCD_ADDR : S_FETCH;
               else if (req_opcode == OP_PRIM)
                  state_in = (esplit_ff || act_cnt != '0) ? S_FETCH : S_GCD_ADDR;
               else
                  state_in = S_GCD_ADDR;
            end
         end
         S_FETCH:     state_in = S_MUL_START;
         S_MUL_START: state_in = q_zero ? S_MUL_RUN : S_RA_ISSUE;
         S_RA_ISSUE:  state_in = S_RA_WAIT;
         S_RA_WAIT:   if (div_rsp.done) state_in = S_RB_ISSUE;
         S_RB_ISSUE:  state_in = S_RB_WAIT;
         S_RB_WAIT:   if (div_rsp.done) state_in = S_MUL_RUN;
         S_MUL_RUN: begin
            if (mul_cnt_ff == CNT_W'(DATA_W - 1))
               state_in = second_ff ? S_DECIDE : S_STEP;
         end
         S_STEP: begin
            if (op_ff == OP_PRIM && !spec_ff && pri_q_ff != '0)
               state_in = S_PR_ISSUE;
            else
               state_in = S_DECIDE;
         end
         S_PR_ISSUE:  state_in = S_PR_WAIT;
         S_PR_WAIT: begin
            if (div_rsp.done)
               state_in = (div_rsp.remainder == '0) ? S_MUL_START : S_DECIDE;
         end
         S_DECIDE: begin
            if (sum_ff < {2'b00, gexp_ff} || k_inc >= act_cnt)
               state_in = S_GCD_ADDR;
            else
               state_in = S_FETCH;
         end
         S_GCD_ADDR: begin
            if (j_ff < act_cnt)
               state_in = S_GCD_LOAD;
            else if (g_ff != '0)
               state_in = S_OR_ISSUE;
            else
               state_in = (op_ff == OP_READ) ? S_RD_ADDR : S_FINISH;
         end
         S_GCD_LOAD:  state_in = S_GCD_RUN;
         S_GCD_RUN:   if (g_done) state_in = S_GCD_ADDR;
         S_OR_ISSUE:  state_in = S_OR_WAIT;
         S_OR_WAIT: begin
            if (div_rsp.done)
               state_in = (op_ff == OP_READ) ? S_RD_ADDR : S_FINISH;
         end
         S_RD_ADDR:   state_in = S_RD_ISSUE;
         S_RD_ISSUE:  state_in = (g_ff == '0) ? S_FINISH : S_RD_WAIT;
         S_RD_WAIT:   if (div_rsp.done) state_in = S_FINISH;
         S_FINISH:    if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall        = (state_ff != S_IDLE);
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = modulus_ff;
      rd_addr          = k_ff[COMP_W-1:0];
      tbl_rd           = 1'b0;
      unique case (state_ff)
         S_FETCH: tbl_rd = 1'b1;
         S_RA_ISSUE: begin
            div_req.start    = 1'b1;
            div_req.dividend = {2'b00, idx_ff};
         end
         S_RB_ISSUE: begin
            div_req.start    = 1'b1;
            div_req.dividend = {2'b00, gen_q_ff};
         end
         S_PR_ISSUE: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = pri_q_ff;
         end
         S_OR_ISSUE: begin
            div_req.start    = 1'b1;
            div_req.dividend = {2'b00, gexp_ff};
            div_req.divisor  = g_ff;
         end
         S_RD_ISSUE: begin
            div_req.start    = (g_ff != '0);
            div_req.dividend = {2'b00, exp_q_ff};
            div_req.divisor  = g_ff;
         end
         S_GCD_ADDR: rd_addr = j_ff[COMP_W-1:0];
         S_RD_ADDR:  rd_addr = comp_ff;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= 32'd1;
         gexp_ff      <= 32'd1;
         ncomp_ff     <= 5'd1;
         esplit_ff    <= 1'b0;
         idx_ff       <= 32'd1;
         exp_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODULUS:  modulus_ff <= csr_wdata;
               CSR_GROUPEXP: gexp_ff    <= csr_wdata;
               CSR_NCOMP:    ncomp_ff   <= csr_wdata[CNT_W-1:0];
               CSR_ESPLIT:   esplit_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept && req_opcode == OP_TRIVIAL) begin
            idx_ff     <= 32'd1;
            exp_vld_ff <= '0;
         end
         if (state_ff == S_MUL_RUN && mul_cnt_ff == CNT_W'(DATA_W - 1))
            idx_ff <= mul_r_in;
         if (state_ff == S_DECIDE)
            exp_vld_ff[k_ff[COMP_W-1:0]] <= 1'b1;
         // refill wins over drain; a drained slot clears
         if (state_ff == S_FINISH && slot_free)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // tables and payload
   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_LOAD) begin
         gen_mem[req_component] <= req_generator_value;
         phi_mem[req_component] <= req_phi_step;
         pri_mem[req_component] <= req_prime_value;
      end
      if (tbl_rd) begin
         gen_q_ff <= gen_mem[rd_addr];
         phi_q_ff <= phi_mem[rd_addr];
         pri_q_ff <= pri_mem[rd_addr];
      end
      exp_q_ff <= exp_vld_ff[rd_addr] ? exp_mem[rd_addr] : '0;
      if (state_ff == S_DECIDE)
         exp_mem[k_ff[COMP_W-1:0]] <=
            (sum_ff < {2'b00, gexp_ff}) ? sum_ff[DATA_W-1:0] :
            ((spec_ff || op_ff == OP_NEXT) ? '0 : phi_q_ff);
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_ff     <= req_opcode;
               comp_ff   <= req_component;
               k_ff      <= '0;
               j_ff      <= '0;
               g_ff      <= gexp_ff;
               readv_ff  <= '0;
               second_ff <= 1'b0;
               spec_ff   <= (req_opcode == OP_PRIM) && esplit_ff;
               last_ff   <= (req_opcode == OP_LOAD || req_opcode == OP_READ) ?
                            {1'b0, req_component} : '0;
            end
         end
         S_MUL_START: begin
            mul_a_ff   <= idx_ff;
            mul_b_ff   <= gen_q_ff;
            mul_r_ff   <= '0;
            mul_cnt_ff <= '0;
         end
         S_RA_WAIT: if (div_rsp.done) mul_a_ff <= div_rsp.remainder;
         S_RB_WAIT: if (div_rsp.done) mul_b_ff <= div_rsp.remainder;
         S_MUL_RUN: begin
            mul_r_ff   <= mul_r_in;
            mul_b_ff   <= {mul_b_ff[DATA_W-2:0], 1'b0};
            mul_cnt_ff <= mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == CNT_W'(DATA_W - 1) && second_ff)
               sum_ff <= sum_ff + {2'b00, phi_q_ff};
         end
         S_STEP: begin
            sum_ff <= {2'b00, exp_q_ff} + (spec_ff ? SUM_W'(1) : {2'b00, phi_q_ff});
         end
         S_PR_WAIT: if (div_rsp.done && div_rsp.remainder == '0) second_ff <= 1'b1;
         S_DECIDE: begin
            second_ff <= 1'b0;
            spec_ff   <= 1'b0;
            if (sum_ff < {2'b00, gexp_ff}) begin
               last_ff <= k_ff;
            end else begin
               k_ff <= k_inc;
               if (k_inc >= act_cnt)
                  last_ff <= k_inc;
            end
         end
         S_GCD_ADDR: if (j_ff >= act_cnt && g_ff == '0) order_ff <= 32'd1;
         S_GCD_LOAD: begin
            ga_ff <= g_ff;
            gb_ff <= exp_q_ff;
            sh_ff <= '0;
         end
         S_GCD_RUN: begin
            ga_ff <= ga_in;
            gb_ff <= gb_in;
            sh_ff <= sh_in;
            if (g_done) begin
               g_ff <= g_res;
               j_ff <= j_ff + 1'b1;
            end
         end
         S_OR_WAIT: if (div_rsp.done) order_ff <= div_rsp.quotient[DATA_W-1:0];
         S_RD_ISSUE: if (g_ff == '0) readv_ff <= exp_q_ff;
         S_RD_WAIT: if (div_rsp.done) readv_ff <= div_rsp.quotient[DATA_W-1:0];
         S_FINISH: begin
            if (slot_free) begin
               rsp_index_ff <= idx_ff;
               rsp_order_ff <= order_ff;
               rsp_last_ff  <= last_ff;
               rsp_read_ff  <= readv_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_index    = rsp_index_ff;
   assign rsp_char_order    = rsp_order_ff;
   assign rsp_last_modified = rsp_last_ff;
   assign rsp_exponent_read = rsp_read_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("engine not busy after accepting an operation");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_index_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_RUN && mul_cnt_ff == CNT_W'(DATA_W - 1) && !q_zero)
      |=> idx_ff < modulus_ff)
      else $error("index not reduced modulo q");

endmodule

/* tb/dirichlet_character_enumerator_tb.sv */
`timescale 1ns / 1ps

module dirichlet_character_enumerator_tb;
   import dce_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;  // idle cycles with work outstanding
   localparam int DRAIN_CYCLES   = 50;
   localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
   localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

   typedef struct {
      logic [2:0]        opcode;
      logic [COMP_W-1:0] component;
      logic [DATA_W-1:0] generator;
      logic [DATA_W-1:0] phi;
      logic [DATA_W-1:0] prime;
   } op_item_type;

   typedef struct {
      logic [DATA_W-1:0] char_index;
      logic [DATA_W-1:0] char_order;
      logic [CNT_W-1:0]  last_modified;
      logic [DATA_W-1:0] exponent_read;
   } char_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_opcode = OP_LOAD;
   logic [COMP_W-1:0]   req_component = '0;
   logic [DATA_W-1:0]   req_generator_value = '0;
   logic [DATA_W-1:0]   req_phi_step = '0;
   logic [DATA_W-1:0]   req_prime_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_char_index;
   logic [DATA_W-1:0]   rsp_char_order;
   logic [CNT_W-1:0]    rsp_last_modified;
   logic [DATA_W-1:0]   rsp_exponent_read;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = CSR_MODULUS;
   logic [DATA_W-1:0]   csr_wdata = '0;

   dirichlet_character_enumerator dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Character state mirror: registers, tables and the running character.
   // ---------------------------------------------------------------------
   logic [63:0] cfg_modulus = 1, cfg_gexp = 1, cfg_ncomp = 1, cfg_split = 0;
   logic [63:0] cur_index = 1;
   logic [63:0] expo_tbl [MAX_COMP];
   logic [63:0] gen_tbl  [MAX_COMP];
   logic [63:0] phi_tbl  [MAX_COMP];
   logic [63:0] prime_tbl[MAX_COMP];

   op_item_type     pending_ops[$];   // queued, not yet transferred
   char_status_type expected_status[$];
   op_item_type     cur_op;

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;        // no idling on either side
   bit  hold_request = 0; // asks the receiver for one long hold-off
   bit  done = 0;

   // product mod q; q == 0 means plain 32-bit wrap
   function automatic logic [63:0] modmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] q, r;
      q = cfg_modulus & MASK32;
      r = 0;
      if (q == 0) return (a * b) & MASK32;
      a = a % q;
      b = b % q;
      while (b != 0) begin
         if (b[0]) begin
            r = r + a;
            if (r >= q) r = r - q;
         end
         a = a + a;
         if (a >= q) a = a - q;
         b = b >> 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] gcd(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic int active_count();
      return (cfg_ncomp > MAX_COMP) ? MAX_COMP : int'(cfg_ncomp);
   endfunction

   // plain mixed-radix step: every wrapped digit returns to zero
   function automatic int advance_character();
      int k, cnt;
      logic [63:0] s;
      cnt = active_count();
      for (k = 0; k < cnt; k++) begin
         cur_index = modmul(cur_index, gen_tbl[k]);
         s = expo_tbl[k] + phi_tbl[k];
         if (s < cfg_gexp) begin
            expo_tbl[k] = s;
            break;
         end
         expo_tbl[k] = 0;
      end
      return k;
   endfunction

   // primitive step: split 2-part counts by one, digits skip multiples of p
   function automatic int advance_primitive();
      int k, cnt;
      logic [63:0] s;
      cnt = active_count();
      k = 0;
      if (cfg_split[0]) begin
         cur_index = modmul(cur_index, gen_tbl[0]);
         s = expo_tbl[0] + 1;
         if (s < cfg_gexp) begin
            expo_tbl[0] = s;
            return 0;
         end
         expo_tbl[0] = 0;
         k = 1;
      end
      for (; k < cnt; k++) begin
         cur_index = modmul(cur_index, gen_tbl[k]);
         s = expo_tbl[k] + phi_tbl[k];
         if (prime_tbl[k] != 0 && s % prime_tbl[k] == 0) begin
            cur_index = modmul(cur_index, gen_tbl[k]);
            s = s + phi_tbl[k];
         end
         if (s < cfg_gexp) begin
            expo_tbl[k] = s;
            break;
         end
         expo_tbl[k] = phi_tbl[k] & MASK32;
      end
      return k;
   endfunction

   function automatic char_status_type apply_op(op_item_type it);
      char_status_type res;
      logic [63:0] g;
      int last;
      last = 0;
      case (it.opcode)
         OP_LOAD: begin
            gen_tbl[it.component]   = {32'd0, it.generator};
            phi_tbl[it.component]   = {32'd0, it.phi};
            prime_tbl[it.component] = {32'd0, it.prime};
            last = it.component;
         end
         OP_TRIVIAL: begin
            cur_index = 1;
            foreach (expo_tbl[i]) expo_tbl[i] = 0;
         end
         OP_NEXT: last = advance_character();
         OP_PRIM: last = advance_primitive();
         OP_READ: last = it.component;
         default: ;
      endcase
      g = cfg_gexp;
      for (int k = 0; k < active_count(); k++) g = gcd(g, expo_tbl[k]);
      res.char_index    = cur_index[31:0];
      res.char_order    = (g != 0) ? 32'((cfg_gexp / g) & MASK32) : 32'd1;
      res.last_modified = last[CNT_W-1:0];
      res.exponent_read = '0;
      if (it.opcode == OP_READ)
         res.exponent_read = (g != 0) ? 32'(expo_tbl[it.component] / g)
                                      : 32'(expo_tbl[it.component]);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: pulls from pending_ops, predicts at each transfer.
   // Valid gets at most one NBA per edge, so back-to-back stays high.
   // ---------------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_status.push_back(apply_op(cur_op));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               req_opcode          <= cur_op.opcode;
               req_component       <= cur_op.component;
               req_generator_value <= cur_op.generator;
               req_phi_step        <= cur_op.phi;
               req_prime_value     <= cur_op.prime;
               req_valid           <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   int stall_left = 0;
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker: field by field against the oldest expectation.
   always @(posedge clock) begin
      char_status_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer, index %h", rsp_char_index);
         end else begin
            exp_s = expected_status.pop_front();
            if (rsp_char_index !== exp_s.char_index || rsp_char_order !== exp_s.char_order ||
                rsp_last_modified !== exp_s.last_modified ||
                rsp_exponent_read !== exp_s.exponent_read) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: index %h/%h order %h/%h last %0d/%0d expo %h/%h (exp/act)",
                           exp_s.char_index, rsp_char_index, exp_s.char_order, rsp_char_order,
                           exp_s.last_modified, rsp_last_modified,
                           exp_s.exponent_read, rsp_exponent_read);
            end
         end
      end
   end

   // Watchdog: only counts while work is outstanding.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_ops.size() == 0 && expected_status.size() == 0 && !req_valid))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic send_op(logic [2:0] opc, logic [31:0] comp = 0,
                          logic [31:0] gen = 0, logic [31:0] phi = 0, logic [31:0] prm = 0);
      op_item_type it;
      it.opcode = opc;
      it.component = comp[COMP_W-1:0];
      it.generator = gen;
      it.phi = phi;
      it.prime = prm;
      pending_ops.push_back(it);
   endtask

   // sampled away from the active edge so queue and valid updates are settled
   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_status.size() != 0 || req_valid)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MODULUS:  cfg_modulus = {32'd0, val};
         CSR_GROUPEXP: cfg_gexp = {32'd0, val};
         CSR_NCOMP:    cfg_ncomp = {59'd0, val[4:0]};
         CSR_ESPLIT:   cfg_split = {63'd0, val[0]};
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] q, logic [31:0] e, logic [31:0] n, logic [31:0] s);
      csr_write(CSR_MODULUS, q);
      csr_write(CSR_GROUPEXP, e);
      csr_write(CSR_NCOMP, n);
      csr_write(CSR_ESPLIT, s);
   endtask

   // phi mostly below E so carries ripple; now and then an extreme
   function automatic logic [31:0] pick_phi();
      case ($urandom_range(0, 9))
         0: return 32'hFFFF_FFFF;
         1: return 0;
         2: return $urandom;
         default: return (cfg_gexp > 1 && cfg_gexp < 64'h1_0000)
                         ? $urandom_range(1, int'(cfg_gexp) - 1) : $urandom_range(1, 9);
      endcase
   endfunction

   function automatic logic [31:0] pick_prime();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom;
         default: return $urandom_range(1, 7);
      endcase
   endfunction

   task automatic random_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)       send_op(OP_LOAD, $urandom, $urandom, pick_phi(), pick_prime());
      else if (r < 14) send_op(OP_TRIVIAL, $urandom, $urandom, $urandom, $urandom);
      else if (r < 52) send_op(OP_NEXT, $urandom);
      else if (r < 84) send_op(OP_PRIM, $urandom);
      else if (r < 97) send_op(OP_READ, $urandom);
      else             send_op(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic random_config();
      logic [31:0] q, e, n;
      case ($urandom_range(0, 3))
         0: q = 0;
         1: q = 32'hFFFF_FFFF;
         2: q = $urandom_range(2, 1000);
         default: q = $urandom;
      endcase
      case ($urandom_range(0, 7))
         0: e = 0;
         1: e = 1;
         2: e = 32'hFFFF_FFFF;
         default: e = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 4))
         0: n = $urandom_range(17, 31);  // saturates at the table size
         1: n = 0;
         default: n = $urandom_range(1, 16);
      endcase
      set_config(q, e, n, $urandom_range(0, 1));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_state();
      send_op(OP_READ, 0);
      send_op(OP_READ, 15);
      send_op(3'd5, 10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(3'd6);
      send_op(3'd7, 5, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      wait_drained();
   endtask

   // fill every table entry so no step ever reads an unwritten one
   task automatic test_load_tables();
      send_op(OP_LOAD, 0, 0, 32'hFFFF_FFFF, 1);
      send_op(OP_LOAD, 1, 32'hFFFF_FFFF, 0, 0);
      send_op(OP_LOAD, 2, $urandom, 1, 32'hFFFF_FFFF);
      for (int c = 3; c < MAX_COMP; c++)
         send_op(OP_LOAD, c, $urandom, $urandom_range(1, 5), $urandom_range(0, 5));
      wait_drained();
   endtask

   task automatic test_steps_basic();
      set_config(32'd97, 32'd6, 32'd16, 32'd1);
      send_op(OP_TRIVIAL);
      send_op(OP_NEXT);
      send_op(OP_PRIM);
      send_op(OP_READ, 2);
      wait_drained();
   endtask

   task automatic test_config_extremes();
      set_config(0, 0, 0, 1);              // zero modulus and exponent, split with no parts
      repeat (6) random_op();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 0);
      repeat (6) random_op();
      set_config(1, 1, 16, 0);
      repeat (6) random_op();
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_config(32'd1009, 32'd12, 32'd4, 32'd0);
      hold_request = 1;
      repeat (30) random_op();
      wait_drained();
   endtask

   task automatic test_random_walk(int phases, int per_phase, bit no_idle);
      for (int p = 0; p < phases; p++) begin
         random_config();
         quiet = no_idle;
         repeat (per_phase) random_op();
         wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_load_tables();
      test_steps_basic();
      test_config_extremes();
      test_backpressure();
      test_random_walk(7, 110, 0);
      test_random_walk(1, 90, 1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      done = 1;
      if (mismatches == 0 && expected_status.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/dce_pkg.sv
rtl/dce_div.sv
rtl/dirichlet_character_enumerator.sv
tb/dirichlet_character_enumerator_tb.sv
